[sv/b64e_pkg.sv]
// Package for the Base64 stream encoder.
// Holds the channel payload types, the job record passed front to back and the alphabet map.
// No dependencies.
package b64e_pkg;

  localparam int unsigned JobChars  = 4;
  localparam int unsigned QueueDepth = 2;

  localparam logic [6:0] PAD_CHAR   = 7'h3D;
  localparam logic [6:0] UPPER_BASE = 7'd65;  // 'A'
  localparam logic [6:0] LOWER_OFS  = 7'd71;  // 'a' - 26
  localparam logic [6:0] DIGIT_OFS  = 7'd4;   // 52 - '0'
  localparam logic [6:0] PLUS_CHAR  = 7'h2B;
  localparam logic [6:0] SLASH_CHAR = 7'h2F;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
  } in_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic       out_last;
  } out_t;

  // Characters produced by one byte; cnt_m1 is the index of the final one.
  typedef struct packed {
    logic [JobChars-1:0][6:0] chars;
    logic [1:0]               cnt_m1;
    logic                     last;
  } job_t;

  typedef enum logic [2:0] {
    PH_START = 3'b001,
    PH_ONE   = 3'b010,
    PH_TWO   = 3'b100
  } phase_t;

  function automatic logic [6:0] sextet_char(input logic [5:0] v);
    logic [6:0] w;
    logic [6:0] c;
    w = {1'b0, v};
    if (v < 6'd26) begin
      c = w + UPPER_BASE;
    end else if (v < 6'd52) begin
      c = w + LOWER_OFS;
    end else if (v < 6'd62) begin
      c = w - DIGIT_OFS;
    end else if (v == 6'd62) begin
      c = PLUS_CHAR;
    end else begin
      c = SLASH_CHAR;
    end
    return c;
  endfunction

endpackage

[sv/base64_stream_encoder_top.sv]
// Top level of the Base64 stream encoder (standard alphabet, '=' padding).
// Depends on b64e_pkg, b64e_front, b64e_queue and b64e_back.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one message byte per
//   transfer, with is_last set on the final byte of the message. Output channel
//   (out_valid / out_stall / out_data) carries one ASCII character per
//   transfer; out_last marks the final character of the encoded message,
//   padding included.
//   A byte yields one to four characters: one or two inside a message, and on
//   the last byte two characters plus zero to two '='.
//   A byte is written into the job queue at its transfer; its first character
//   then moves into the output register once that register is open.
//   Throughput: the output register emits one character per cycle unless the
//   receiver stalls; a byte yields 1 to 4 characters, about 4/3 on a long
//   message. The front takes a byte every cycle while the two-entry job queue
//   has room. Reset (rst, synchronous) clears the group phase, empties the
//   queue and drops out_valid. When the receiver stalls, the output character
//   holds, the queue fills, and then in_stall rises until space frees up.
module base64_stream_encoder_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  b64e_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output b64e_pkg::out_t out_data
);

  logic           fq_valid, fq_stall;
  b64e_pkg::job_t fq_job;
  logic           qb_valid, qb_stall;
  b64e_pkg::job_t qb_job;

  b64e_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .job_valid (fq_valid),
    .job_stall (fq_stall),
    .job       (fq_job)
  );

  b64e_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_stall (fq_stall),
    .push_job   (fq_job),
    .pop_valid  (qb_valid),
    .pop_stall  (qb_stall),
    .pop_job    (qb_job)
  );

  b64e_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (qb_valid),
    .job_stall (qb_stall),
    .job       (qb_job),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Every accepted byte lands in the queue in the same cycle.
  a_accept_pushes: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> (fq_valid && !fq_stall))
    else $error("accepted byte not written to job queue");

  // With the queue empty, a taken character leaves the output empty.
  a_drain_empty: assert property (@(posedge clk) disable iff (rst)
    (!qb_valid && out_valid && !out_stall) |=> !out_valid)
    else $error("output valid without a queued job");

  // Reset empties the output register.
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  // A stalled output never releases a job from the queue.
  a_hold_job: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> qb_stall)
    else $error("job released while output stalled");

endmodule

[sv/b64e_front.sv]
// Front end of the Base64 stream encoder: accepts bytes, tracks the group phase
// and builds one job of one to four characters per byte. Depends on b64e_pkg.
module b64e_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  b64e_pkg::in_t  in_data,
  output logic           job_valid,
  input  logic           job_stall,
  output b64e_pkg::job_t job
);

  b64e_pkg::phase_t phase, phase_next;
  logic [3:0]       leftover, leftover_next;
  logic             take;
  logic [7:0]       b;

  assign b         = in_data.data_byte;
  assign job_valid = in_valid;
  assign in_stall  = job_stall;
  assign take      = in_valid && !job_stall;

  always_comb begin
    job.chars     = '{default: b64e_pkg::PAD_CHAR};
    job.cnt_m1    = 2'd0;
    job.last      = in_data.is_last;
    phase_next    = phase;
    leftover_next = leftover;
    unique case (phase)
      b64e_pkg::PH_ONE: begin
        job.chars[0]  = b64e_pkg::sextet_char({leftover[1:0], b[7:4]});
        phase_next    = b64e_pkg::PH_TWO;
        leftover_next = b[3:0];
        if (in_data.is_last) begin
          job.chars[1] = b64e_pkg::sextet_char({b[3:0], 2'b00});
          job.cnt_m1   = 2'd2;
        end
      end
      b64e_pkg::PH_TWO: begin
        job.chars[0]  = b64e_pkg::sextet_char({leftover, b[7:6]});
        job.chars[1]  = b64e_pkg::sextet_char(b[5:0]);
        job.cnt_m1    = 2'd1;
        phase_next    = b64e_pkg::PH_START;
        leftover_next = 4'd0;
      end
      default: begin
        job.chars[0]  = b64e_pkg::sextet_char(b[7:2]);
        phase_next    = b64e_pkg::PH_ONE;
        leftover_next = {2'b00, b[1:0]};
        if (in_data.is_last) begin
          job.chars[1] = b64e_pkg::sextet_char({b[1:0], 4'b0000});
          job.cnt_m1   = 2'd3;
        end
      end
    endcase
    // End of message: back to the start of a group.
    if (in_data.is_last) begin
      phase_next    = b64e_pkg::PH_START;
      leftover_next = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= b64e_pkg::PH_START;
      leftover <= 4'd0;
    end else if (take) begin
      phase    <= phase_next;
      leftover <= leftover_next;
    end
  end

endmodule

[sv/b64e_queue.sv]
// Two-entry job queue between the front and back of the Base64 encoder.
// Depends on b64e_pkg.
module b64e_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_stall,
  input  b64e_pkg::job_t push_job,
  output logic           pop_valid,
  input  logic           pop_stall,
  output b64e_pkg::job_t pop_job
);

  b64e_pkg::job_t entries [b64e_pkg::QueueDepth];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       push, pop;

  assign push_stall = (count == 2'(b64e_pkg::QueueDepth));
  assign pop_valid  = (count != 2'd0);
  assign pop_job    = entries[rd_ptr];
  assign push       = push_valid && !push_stall;
  assign pop        = pop_valid && !pop_stall;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

[sv/b64e_back.sv]
// Back end of the Base64 encoder: walks the characters of each queued job and
// drives the output register one character per cycle unless stalled. Depends on b64e_pkg.
module b64e_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_valid,
  output logic           job_stall,
  input  b64e_pkg::job_t job,
  output logic           out_valid,
  input  logic           out_stall,
  output b64e_pkg::out_t out_data
);

  logic [1:0] idx;
  logic       open;
  logic       load;
  logic       final_char;

  assign open       = !out_valid || !out_stall;
  assign load       = open && job_valid;
  assign final_char = (idx == job.cnt_m1);
  // Release the job once its final character moves into the output register.
  assign job_stall  = !(open && final_char);

  always_ff @(posedge clk) begin
    if (load) begin
      out_data.out_char <= job.chars[idx];
      out_data.out_last <= final_char && job.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (open) begin
        out_valid <= job_valid;
      end
      if (load) begin
        idx <= final_char ? 2'd0 : idx + 2'd1;
      end
    end
  end

endmodule
